@@ hdl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lge_pkg.sv @@
`default_nettype none

package lge_pkg;

	localparam int GRID_COLS_DEF = 40;
	localparam int GRID_ROWS_DEF = 30;

	localparam int ACTION_W = 2;
	localparam int COL_W    = 6;
	localparam int ROW_W    = 5;

	localparam logic [ACTION_W-1:0] ACT_TOGGLE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_STEP   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;     // item transfer this cycle
		logic cell_fin;   // finish a toggle, read or no-op
		logic step_rd;    // fetch one row of the old generation
		logic step_shift; // advance the row window
		logic step_wr;    // write one row of the new generation
		logic finish;     // load the result registers
	} cmd_t;

endpackage

`default_nettype wire

@@ hdl/lge_ram.sv @@
`default_nettype none

module lge_ram #(
	parameter int WIDTH = lge_pkg::GRID_COLS_DEF,
	parameter int DEPTH = lge_pkg::GRID_ROWS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/lge_ctrl.sv @@
`default_nettype none

module lge_ctrl #(
	parameter int GRID_ROWS = lge_pkg::GRID_ROWS_DEF,
	localparam int RW = $clog2(GRID_ROWS),
	localparam int KW = $clog2(GRID_ROWS + 2)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [lge_pkg::ACTION_W-1:0]  action,
	output logic                               busy,
	output lge_pkg::cmd_t                      cmd,
	output logic      [RW-1:0]                 step_rd_row,
	output logic      [RW-1:0]                 step_wr_row
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CELL,
		S_STEP
	} state_t;

	localparam logic [KW-1:0] K_ROWS = KW'(GRID_ROWS);
	localparam logic [KW-1:0] K_LAST = KW'(GRID_ROWS + 1);
	localparam logic [KW-1:0] K_TWO  = KW'(2);

	state_t        state_q;
	logic          busy_q;
	logic [KW-1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						k_q    <= '0;
						busy_q <= 1'b1;
						state_q <= (action == lge_pkg::ACT_STEP) ? S_STEP : S_CELL;
					end
				end
				S_CELL: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				S_STEP: begin
					if (k_q == K_LAST) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd.accept     = (state_q == S_IDLE) && start;
		cmd.cell_fin   = (state_q == S_CELL);
		cmd.step_rd    = (state_q == S_STEP) && (k_q < K_ROWS);
		cmd.step_shift = (state_q == S_STEP) && (k_q != '0);
		cmd.step_wr    = (state_q == S_STEP) && (k_q >= K_TWO);
		cmd.finish     = cmd.cell_fin || ((state_q == S_STEP) && (k_q == K_LAST));
	end

	assign busy        = busy_q;
	assign step_rd_row = k_q[RW-1:0];
	assign step_wr_row = RW'(k_q - K_TWO);

endmodule

`default_nettype wire

@@ hdl/lge_datapath.sv @@
`default_nettype none

module lge_datapath #(
	parameter int GRID_COLS = lge_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = lge_pkg::GRID_ROWS_DEF,
	localparam int RW = $clog2(GRID_ROWS),
	localparam int CW = $clog2(GRID_COLS)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lge_pkg::cmd_t                 cmd,
	input  wire logic [RW-1:0]                 step_rd_row,
	input  wire logic [RW-1:0]                 step_wr_row,
	input  wire logic [lge_pkg::ACTION_W-1:0]  action,
	input  wire logic [lge_pkg::COL_W-1:0]     col,
	input  wire logic [lge_pkg::ROW_W-1:0]     row,
	output logic                               done,
	output logic                               cell_alive,
	output logic      [lge_pkg::ACTION_W-1:0]  done_action
);

	localparam logic [3:0] BIRTH_CNT   = 4'd3;
	localparam logic [3:0] SURVIVE_CNT = 4'd2;

	// latched item
	logic [lge_pkg::ACTION_W-1:0] act_q;
	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic                         inside_q;

	logic [GRID_ROWS-1:0] row_valid_q;
	logic                 rd_live_s1;
	logic                 done_q;
	logic                 alive_q;
	logic [lge_pkg::ACTION_W-1:0] done_act_q;

	// row window: up_q holds the row above mid_q
	logic [GRID_COLS-1:0] up_q;
	logic [GRID_COLS-1:0] mid_q;

	logic                 inside_now;
	logic [RW-1:0]        row_now;
	logic                 ram_rd_en;
	logic [RW-1:0]        ram_rd_addr;
	logic [GRID_COLS-1:0] ram_rd_data;
	logic                 ram_wr_en;
	logic [RW-1:0]        ram_wr_addr;
	logic [GRID_COLS-1:0] ram_wr_data;
	logic                 live_now;

	logic [GRID_COLS-1:0] in_row;
	logic [GRID_COLS-1:0] tog_row;
	logic [GRID_COLS-1:0] gen_row;
	logic [GRID_COLS+1:0] up_p;
	logic [GRID_COLS+1:0] mid_p;
	logic [GRID_COLS+1:0] dn_p;
	logic [GRID_COLS-1:0][3:0] nbr;
	logic                 cell_bit;
	logic                 cell_res;

	assign inside_now = (32'(col) < GRID_COLS) && (32'(row) < GRID_ROWS);
	assign row_now    = RW'(row);

	assign ram_rd_en   = (cmd.accept && inside_now) || cmd.step_rd;
	assign ram_rd_addr = cmd.step_rd ? step_rd_row : row_now;
	assign live_now    = ram_rd_en ? row_valid_q[ram_rd_addr] : 1'b0;

	// a row never written reads as all dead
	assign in_row  = rd_live_s1 ? ram_rd_data : '0;
	assign tog_row = in_row ^ (GRID_COLS'(1) << col_q);

	assign cell_bit = inside_q ? in_row[col_q] : 1'b0;
	assign cell_res = inside_q && (((act_q == lge_pkg::ACT_TOGGLE) && !cell_bit) ||
		((act_q == lge_pkg::ACT_READ) && cell_bit));

	assign ram_wr_en   = cmd.step_wr ||
		(cmd.cell_fin && inside_q && (act_q == lge_pkg::ACT_TOGGLE));
	assign ram_wr_addr = cmd.step_wr ? step_wr_row : row_q;
	assign ram_wr_data = cmd.step_wr ? gen_row : tog_row;

	assign up_p  = {1'b0, up_q, 1'b0};
	assign mid_p = {1'b0, mid_q, 1'b0};
	assign dn_p  = {1'b0, in_row, 1'b0};

	always_comb begin
		for (int c = 0; c < GRID_COLS; c++) begin
			nbr[c] = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2]) +
				4'(mid_p[c]) + 4'(mid_p[c+2]) +
				4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
			gen_row[c] = (nbr[c] == BIRTH_CNT) || ((nbr[c] == SURVIVE_CNT) && mid_p[c+1]);
		end
	end

	lge_ram #(
		.WIDTH (GRID_COLS),
		.DEPTH (GRID_ROWS)
	) u_grid (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_live_s1  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (ram_wr_en) begin
				row_valid_q[ram_wr_addr] <= 1'b1;
			end
			rd_live_s1 <= live_now;
			done_q     <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q    <= action;
			col_q    <= CW'(col);
			row_q    <= row_now;
			inside_q <= inside_now;
			up_q     <= '0;
			mid_q    <= '0;
		end else if (cmd.step_shift) begin
			up_q  <= mid_q;
			mid_q <= in_row;
		end
		if (cmd.finish) begin
			alive_q    <= cell_res;
			done_act_q <= act_q;
		end
	end

	assign done        = done_q;
	assign cell_alive  = alive_q;
	assign done_action = done_act_q;

endmodule

`default_nettype wire

@@ hdl/life_grid_engine.sv @@
// Toggle, read or no-op: the transfer latches the item, S_CELL makes the access while busy, and
//   done_q then strobes the result; a new item may be taken while that result shows.
// Generation step: busy through the S_STEP sweep, set by the single grid read port sweeping
//   one row a cycle; done_q then strobes the result.
// Reset (arst_n, asynchronous, active low) idles the controller and marks every row of the
//   grid unwritten, so all cells read dead at once; no clearing pass. The receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"

module life_grid_engine #(
	parameter int GRID_COLS = lge_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = lge_pkg::GRID_ROWS_DEF,
	localparam int RW = $clog2(GRID_ROWS)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [lge_pkg::ACTION_W-1:0]  action,
	input  wire logic [lge_pkg::COL_W-1:0]     col,
	input  wire logic [lge_pkg::ROW_W-1:0]     row,
	output logic                               busy,
	output logic                               done,
	output logic                               cell_alive,
	output logic      [lge_pkg::ACTION_W-1:0]  done_action
);

	// The grid lives in a row-wide memory, one word per grid row. A step reads the old
	// generation top to bottom, keeps the two rows above the incoming one in a window,
	// and writes each new row behind the read pointer, so the old rows it still needs
	// are always held in the window rather than re-read from memory.

	lge_pkg::cmd_t cmd;
	logic [RW-1:0] step_rd_row;
	logic [RW-1:0] step_wr_row;

	// Sequence item transfers, the single-cell access and the row sweep
	lge_ctrl #(
		.GRID_ROWS (GRID_ROWS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.busy        (busy),
		.cmd         (cmd),
		.step_rd_row (step_rd_row),
		.step_wr_row (step_wr_row)
	);

	// Hold the grid, apply the rule across a whole row and register the result
	lge_datapath #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.step_rd_row (step_rd_row),
		.step_wr_row (step_wr_row),
		.action      (action),
		.col         (col),
		.row         (row),
		.done        (done),
		.cell_alive  (cell_alive),
		.done_action (done_action)
	);

	// A result always shows with the controller back in idle, after a busy cycle
	`CHK_IMPLY(a_done_idle, clk, arst_n, done, !busy, "result shown while busy")
	`CHK_IMPLY(a_done_after_busy, clk, arst_n, done, $past(busy), "result without work")
	// A cell transfer gives its result through S_CELL and the done register
	`CHK_IMPLY(a_cell_latency, clk, arst_n,
		start && !busy && (action != lge_pkg::ACT_STEP), ##2 done, "cell result late")
	// A step transfer holds the block busy for the sweep
	`CHK_NEXT(a_step_busy, clk, arst_n,
		start && !busy && (action == lge_pkg::ACT_STEP), busy && !done, "step not started")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none

// Checks the cell grid engine: toggles, reads and generation steps are sent through the
// start/busy handshake and every done strobe is compared against a bit-level model of the grid.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lge_pkg::*;

	localparam int COLS = GRID_COLS_DEF;
	localparam int ROWS = GRID_ROWS_DEF;

	// Action code with no meaning to the engine: it must echo it and change nothing.
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

	// Shadow grid plus the queue of results still owed by the engine.
	class life_tracker;
		typedef struct {
			bit                  alive;
			logic [ACTION_W-1:0] act;
		} outcome_t;

		bit          cells [ROWS][COLS];
		outcome_t    outcome_q [$];
		int unsigned failures;
		int unsigned reported;

		function void flag(string what);
			failures++;
			if (reported < 10) begin
				reported++;
				$display("%0t: %s", $realtime, what);
			end
		endfunction

		function int live_at(int r, int c);
			if (r < 0 || c < 0 || r >= ROWS || c >= COLS)
				return 0;
			return cells[r][c];
		endfunction

		// One generation of B3/S23; every new cell comes from the old grid only.
		function void evolve();
			bit nxt [ROWS][COLS];
			int n;
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					n = 0;
					for (int dr = -1; dr <= 1; dr++)
						for (int dc = -1; dc <= 1; dc++)
							if (dr != 0 || dc != 0)
								n += live_at(r + dr, c + dc);
					nxt[r][c] = (n == 3) || (n == 2 && cells[r][c]);
				end
			end
			cells = nxt;
		endfunction

		function void note_command(logic [ACTION_W-1:0] act, logic [COL_W-1:0] c,
				logic [ROW_W-1:0] r);
			outcome_t o;
			bit on_grid;
			on_grid = (c < COLS) && (r < ROWS);
			o.act = act;
			o.alive = 1'b0;
			case (act)
				ACT_TOGGLE: begin
					if (on_grid) begin
						cells[r][c] = !cells[r][c];
						o.alive = cells[r][c];
					end
				end
				ACT_STEP: evolve();
				ACT_READ: begin
					if (on_grid)
						o.alive = cells[r][c];
				end
				default: ;
			endcase
			outcome_q.push_back(o);
		endfunction

		function void check_result(logic alive, logic [ACTION_W-1:0] act);
			outcome_t o;
			if (outcome_q.size() == 0) begin
				flag($sformatf("result with nothing outstanding: alive %0d action %0d",
					alive, act));
				return;
			end
			o = outcome_q.pop_front();
			if (alive !== o.alive || act !== o.act)
				flag($sformatf("mismatch: expected alive %0d action %0d, got alive %0d action %0d",
					o.alive, o.act, alive, act));
		endfunction

		function int waiting();
			return outcome_q.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [ACTION_W-1:0] action = ACT_READ;
	logic [COL_W-1:0]    col = '0;
	logic [ROW_W-1:0]    row = '0;
	logic                busy;
	logic                done;
	logic                cell_alive;
	logic [ACTION_W-1:0] done_action;

	life_tracker tracker = new();
	int          burst_left = 1;

	life_grid_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.col         (col),
		.row         (row),
		.busy        (busy),
		.done        (done),
		.cell_alive  (cell_alive),
		.done_action (done_action)
	);

	always #1 clk = ~clk;

	// Hard stop well beyond the slowest legal run.
	initial begin
		#1_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// The receiver cannot hold results off: take every strobe as it comes.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(cell_alive, done_action);
	end

	// Close a burst with a random gap, scrambling the idle fields meanwhile; otherwise keep
	// start high so the next transfer follows back to back.
	task automatic pace();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			start <= 1'b0;
			action <= ACTION_W'($urandom);
			col <= COL_W'($urandom);
			row <= ROW_W'($urandom);
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(9) < 3) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
	endtask

	// Present one command from the falling edge and hold it until the engine takes it.
	task automatic transfer(input logic [ACTION_W-1:0] a, input int c, input int r);
		@(negedge clk);
		start <= 1'b1;
		action <= a;
		col <= c[COL_W-1:0];
		row <= r[ROW_W-1:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		tracker.note_command(a, c[COL_W-1:0], r[ROW_W-1:0]);
		pace();
	endtask

	// Pick a coordinate close to a centre, clipped to the grid, so patterns stay dense.
	function automatic int near(int centre, int limit);
		int v;
		v = centre + $urandom_range(0, 4) - 2;
		if (v < 0)
			v = 0;
		if (v >= limit)
			v = limit - 1;
		return v;
	endfunction

	initial begin
		int fc, fr, pick;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: corners, off-grid addresses, the unused code and two still/oscillating shapes.
		transfer(ACT_READ, 0, 0);
		transfer(ACT_TOGGLE, 0, 0);
		transfer(ACT_TOGGLE, COLS - 1, ROWS - 1);
		transfer(ACT_READ, COLS - 1, ROWS - 1);
		transfer(ACT_TOGGLE, 63, 31);
		transfer(ACT_READ, COLS, 0);
		transfer(ACT_READ, 0, ROWS);
		transfer(ACT_NONE, 5, 5);
		transfer(ACT_TOGGLE, 0, 0);
		// Blinker: horizontal bar flips to vertical and back.
		transfer(ACT_TOGGLE, 10, 5);
		transfer(ACT_TOGGLE, 11, 5);
		transfer(ACT_TOGGLE, 12, 5);
		transfer(ACT_STEP, 63, 31);
		transfer(ACT_READ, 11, 4);
		transfer(ACT_READ, 11, 5);
		transfer(ACT_READ, 11, 6);
		transfer(ACT_STEP, 0, 0);
		transfer(ACT_READ, 10, 5);
		// Three cells of a block against the far corner: they must survive and fill the block, no wrap-around.
		transfer(ACT_TOGGLE, COLS - 2, ROWS - 2);
		transfer(ACT_TOGGLE, COLS - 2, ROWS - 1);
		transfer(ACT_TOGGLE, COLS - 1, ROWS - 2);
		transfer(ACT_STEP, 17, 3);
		transfer(ACT_READ, COLS - 2, ROWS - 2);

		// Random: mostly toggles and reads clustered around a wandering focus, with steps in
		// between so shapes grow and die; a little off-grid and unused-code noise.
		fc = $urandom_range(0, COLS - 1);
		fr = $urandom_range(0, ROWS - 1);
		for (int i = 0; i < 480; i++) begin
			if ($urandom_range(9) == 0) begin
				fc = ($urandom_range(3) == 0) ? (($urandom_range(1)) ? COLS - 1 : 0)
					: $urandom_range(0, COLS - 1);
				fr = ($urandom_range(3) == 0) ? (($urandom_range(1)) ? ROWS - 1 : 0)
					: $urandom_range(0, ROWS - 1);
			end
			pick = $urandom_range(99);
			if (pick < 50)
				transfer(ACT_TOGGLE, near(fc, COLS), near(fr, ROWS));
			else if (pick < 65)
				transfer(ACT_STEP, $urandom_range(63), $urandom_range(31));
			else if (pick < 88)
				transfer(ACT_READ, near(fc, COLS), near(fr, ROWS));
			else if (pick < 95)
				transfer(($urandom_range(1)) ? ACT_READ : ACT_TOGGLE,
					$urandom_range(63), $urandom_range(31));
			else
				transfer(ACT_NONE, $urandom_range(63), $urandom_range(31));
		end

		// Drain: drop start, wait for every owed result, then watch for stray strobes.
		@(negedge clk);
		start <= 1'b0;
		while (tracker.waiting() != 0) @(posedge clk);
		repeat (ROWS + 10) @(posedge clk);
		if (tracker.failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

`default_nettype wire
